@@ rtl/simplex_noise_2d_defines.svh @@
// ----------------------------------------------------------------------------
// simplex_noise_2d_defines
// Assertion macros for the simplex noise RTL.
// ----------------------------------------------------------------------------
`ifndef SIMPLEX_NOISE_2D_DEFINES_SVH
`define SIMPLEX_NOISE_2D_DEFINES_SVH

// same-cycle implication
`define SND_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("simplex_noise_2d: same-cycle check failed");

// next-cycle implication
`define SND_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("simplex_noise_2d: next-cycle check failed");

`endif

@@ rtl/snd_pkg.sv @@
// ----------------------------------------------------------------------------
// snd_pkg
// Constants, gradient set and control types of the simplex noise block.
// ----------------------------------------------------------------------------
package snd_pkg;

	localparam int SKEW_F2     = 23988;
	localparam int UNSKEW_G2   = 13849;
	localparam int NOISE_SCALE = 70;

	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;

	localparam logic REG_SEED = 1'b0;

	localparam int QUEUE_DEPTH = 8;
	localparam int QCNT_W      = 4;
	localparam int OUT_DEPTH   = 10;

	typedef struct packed {
		logic       busy;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
		logic [7:0] rd_addr0;
		logic [7:0] rd_addr1;
	} shf_ctrl_t;

	function automatic logic signed [1:0] grad_x(input logic [2:0] g);
		logic signed [1:0] r;
		case (g)
			3'd0, 3'd2, 3'd4: r = 2'sb01;
			3'd1, 3'd3, 3'd5: r = 2'sb11;
			default:          r = 2'sb00;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] grad_y(input logic [2:0] g);
		logic signed [1:0] r;
		case (g)
			3'd0, 3'd1, 3'd6: r = 2'sb01;
			3'd2, 3'd3, 3'd7: r = 2'sb11;
			default:          r = 2'sb00;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/snd_shuffle.sv @@
// ----------------------------------------------------------------------------
// snd_shuffle
// Rebuilds the permutation table: identity fill, then LCG-driven
// Fisher-Yates swaps with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module snd_shuffle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seed_wr,
	input  logic [31:0]         seed_val,
	input  logic [7:0]          rd_data0,
	input  logic [7:0]          rd_data1,
	output snd_pkg::shf_ctrl_t  ctrl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_LCG  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_CAPT = 3'd5;
	localparam logic [2:0] ST_WR1  = 3'd6;
	localparam logic [2:0] ST_WR2  = 3'd7;

	logic [2:0]  state_q;
	logic [7:0]  k_q;
	logic [31:0] st_q;
	logic [15:0] num_q;
	logic [8:0]  rem_q;
	logic [3:0]  cnt_q;
	logic [7:0]  vk_q;
	logic [7:0]  vp_q;

	logic [31:0] st_nx;
	logic [9:0]  rsh;
	logic [9:0]  dvs;
	logic [9:0]  rnew;

	assign st_nx = st_q * snd_pkg::LCG_MUL + snd_pkg::LCG_ADD;

	// one quotient bit per cycle, only the remainder is kept
	always_comb begin
		rsh  = {rem_q, num_q[15]};
		dvs  = {2'b00, k_q} + 10'd1;
		rnew = (rsh >= dvs) ? (rsh - dvs) : rsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			k_q     <= 8'd0;
			st_q    <= 32'd0;
			cnt_q   <= 4'd0;
		end else if (seed_wr) begin
			state_q <= ST_FILL;
			k_q     <= 8'd0;
			st_q    <= seed_val;
			cnt_q   <= 4'd0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (k_q == 8'hFF) begin
						state_q <= ST_LCG;
					end else begin
						k_q <= k_q + 8'd1;
					end
				end
				ST_LCG: begin
					st_q    <= st_nx;
					cnt_q   <= 4'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CAPT;
				ST_CAPT: state_q <= ST_WR1;
				ST_WR1:  state_q <= ST_WR2;
				ST_WR2: begin
					if (k_q == 8'd1) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q - 8'd1;
						state_q <= ST_LCG;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LCG: begin
				num_q <= st_nx[31:16];
				rem_q <= 9'd0;
			end
			ST_DIV: begin
				num_q <= {num_q[14:0], 1'b0};
				rem_q <= rnew[8:0];
			end
			ST_CAPT: begin
				vk_q <= rd_data0;
				vp_q <= rd_data1;
			end
			default: ;
		endcase
	end

	always_comb begin
		ctrl.busy     = (state_q != ST_IDLE);
		ctrl.wr_en    = 1'b0;
		ctrl.wr_addr  = k_q;
		ctrl.wr_data  = k_q;
		ctrl.rd_addr0 = k_q;
		ctrl.rd_addr1 = rem_q[7:0];
		case (state_q)
			ST_FILL: ctrl.wr_en = 1'b1;
			ST_WR1: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_data = vp_q;
			end
			ST_WR2: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_addr = rem_q[7:0];
				ctrl.wr_data = vk_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/snd_front.sv @@
// ----------------------------------------------------------------------------
// snd_front
// Accepts points, skews them to a lattice cell, picks the triangle, hashes
// the three corners through the permutation table and classifies each
// corner as in reach or not. Runs without stalls; the queue gives credit.
// ----------------------------------------------------------------------------
module snd_front #(
	parameter int C = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             x_coord,
	input  logic signed [31:0]             y_coord,
	input  logic [snd_pkg::QCNT_W-1:0]     q_count,
	input  snd_pkg::shf_ctrl_t             ctrl,
	output logic [7:0]                     rd_data0,
	output logic [7:0]                     rd_data1,
	output logic                           push,
	output logic [3*(2*(C+2)+4)-1:0]       push_data
);

	localparam int XW  = 40;
	localparam int DW  = C + 2;
	localparam int CW  = 2 * DW + 4;
	localparam int TSL = (C >= 16) ? C - 16 : 0;
	localparam int TSR = (C >= 16) ? 0 : 16 - C;
	localparam logic signed [XW-1:0] ONE = XW'(longint'(1) << C);
	localparam logic signed [XW-1:0] G2C =
		XW'((longint'(snd_pkg::UNSKEW_G2) << C) >> 16);
	localparam logic signed [15:0] SKEW = 16'(snd_pkg::SKEW_F2);
	localparam logic signed [15:0] UNSK = 16'(snd_pkg::UNSKEW_G2);

	logic [7:0] perm_a [0:255];
	logic [7:0] perm_b [0:255];
	logic [7:0] perm_c [0:255];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0] infl;
	logic accept;

	logic signed [31:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [48:0] skp_s2;
	logic signed [33:0] ci_s3, cj_s3, ci_s4, cj_s4;
	logic signed [49:0] tp_s4;
	logic [7:0]         rda0_s4, rda1_s4;
	logic signed [XW-1:0] x0_s5, y0_s5;
	logic [7:0]         ii_s5, pj0_s5, pj1_s5;
	logic signed [XW-1:0] dx_s6 [3];
	logic signed [XW-1:0] dy_s6 [3];
	logic [7:0]         h_s6 [3];

	logic signed [32:0] xy;
	logic signed [33:0] s_c, xs_c, ys_c;
	logic signed [34:0] csum;
	logic [7:0]         a_addr0, a_addr1;
	logic signed [XW-1:0] t_c, x0_c, y0_c;
	logic               i1;
	logic [7:0]         pjm, b_addr0, b_addr1, c_addr;
	logic signed [XW-1:0] x1_c, y1_c, x2_c, y2_c;

	always_comb begin
		infl = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5) + 3'(v_s6);
		// items in flight all land in the queue, so reserve room for them
		in_ready = !ctrl.busy &&
			(({1'b0, q_count} + 5'(infl)) < 5'(snd_pkg::QUEUE_DEPTH));
		accept = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// skew and cell
	always_comb begin
		xy   = 33'(x_s1) + 33'(y_s1);
		s_c  = 34'(skp_s2 >>> 16);
		xs_c = 34'(x_s2) + s_c;
		ys_c = 34'(y_s2) + s_c;
		csum = 35'(ci_s3) + 35'(cj_s3);
		a_addr0 = ctrl.busy ? ctrl.rd_addr0 : cj_s3[7:0];
		a_addr1 = ctrl.busy ? ctrl.rd_addr1 : cj_s3[7:0] + 8'd1;
	end

	// unskew and corner offsets
	always_comb begin
		t_c  = XW'(tp_s4 >>> TSR) <<< TSL;
		x0_c = XW'(x_s4) - (XW'(ci_s4) <<< C) + t_c;
		y0_c = XW'(y_s4) - (XW'(cj_s4) <<< C) + t_c;
		i1   = (x0_s5 > y0_s5);
		pjm  = i1 ? pj0_s5 : pj1_s5;
		b_addr0 = ii_s5 + pj0_s5;
		b_addr1 = ii_s5 + {7'd0, i1} + pjm;
		c_addr  = ii_s5 + 8'd1 + pj1_s5;
		x1_c = x0_s5 - (i1 ? ONE : '0) + G2C;
		y1_c = y0_s5 - (i1 ? '0 : ONE) + G2C;
		x2_c = x0_s5 - ONE + (G2C <<< 1);
		y2_c = y0_s5 - ONE + (G2C <<< 1);
	end

	always_ff @(posedge clk) begin
		x_s1   <= x_coord;
		y_s1   <= y_coord;
		skp_s2 <= 49'(xy) * 49'(SKEW);
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		ci_s3  <= xs_c >>> C;
		cj_s3  <= ys_c >>> C;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		tp_s4  <= 50'(csum) * 50'(UNSK);
		ci_s4  <= ci_s3;
		cj_s4  <= cj_s3;
		x_s4   <= x_s3;
		y_s4   <= y_s3;
		x0_s5  <= x0_c;
		y0_s5  <= y0_c;
		ii_s5  <= ci_s4[7:0];
		pj0_s5 <= rda0_s4;
		pj1_s5 <= rda1_s4;
		dx_s6[0] <= x0_s5;
		dy_s6[0] <= y0_s5;
		dx_s6[1] <= x1_c;
		dy_s6[1] <= y1_c;
		dx_s6[2] <= x2_c;
		dy_s6[2] <= y2_c;
	end

	// three table copies, same writes, different read ports
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			perm_a[ctrl.wr_addr] <= ctrl.wr_data;
		end
		rda0_s4 <= perm_a[a_addr0];
		rda1_s4 <= perm_a[a_addr1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			perm_b[ctrl.wr_addr] <= ctrl.wr_data;
		end
		h_s6[0] <= perm_b[b_addr0];
		h_s6[1] <= perm_b[b_addr1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			perm_c[ctrl.wr_addr] <= ctrl.wr_data;
		end
		h_s6[2] <= perm_c[c_addr];
	end

	assign rd_data0 = rda0_s4;
	assign rd_data1 = rda1_s4;

	// a corner at a distance of 1.0 or more on either axis has negative falloff
	always_comb begin
		push = v_s6;
		for (int k = 0; k < 3; k++) begin
			push_data[k*CW +: CW] = {
				(dx_s6[k] > -ONE) && (dx_s6[k] < ONE) &&
				(dy_s6[k] > -ONE) && (dy_s6[k] < ONE),
				h_s6[k][2:0],
				dy_s6[k][DW-1:0],
				dx_s6[k][DW-1:0]
			};
		end
	end

endmodule

@@ rtl/snd_fifo.sv @@
// ----------------------------------------------------------------------------
// snd_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module snd_fifo #(
	parameter int W     = 16,
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 push_data,
	input  logic                         pop,
	output logic [W-1:0]                 head,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == NW'(DEPTH));
	assign count = count_q;

endmodule

@@ rtl/snd_back.sv @@
// ----------------------------------------------------------------------------
// snd_back
// Falloff, gradient dot product and corner contributions for three lanes,
// sum, scale by 70 and saturate. Pops the queue only with room downstream.
// ----------------------------------------------------------------------------
module snd_back #(
	parameter int C = 16,
	parameter int O = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [3*(2*(C+2)+4)-1:0]     q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           noise_value
);

	localparam int DW  = C + 2;
	localparam int CW  = 2 * DW + 4;
	localparam int FW  = C + 3;
	localparam int DTW = C + 3;
	localparam int PW  = 2 * C + 4;
	localparam int SW  = C + 6;
	localparam int VW  = C + 22;
	localparam int SQW = 2 * DW;
	localparam int MW  = 2 * C;
	localparam int SR  = (C >= O) ? C - O : 0;
	localparam int SL  = (C >= O) ? 0 : O - C;
	localparam int OCW = $clog2(snd_pkg::OUT_DEPTH + 1);
	localparam logic signed [FW-1:0] HALF = FW'(longint'(1) << (C - 1));

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [2:0] infl;

	logic signed [DW-1:0]    dx_s1 [3];
	logic signed [DW-1:0]    dy_s1 [3];
	logic [2:0]              g_s1  [3];
	logic                    al_s1 [3];
	logic signed [2*DW-1:0]  sqx_s2 [3];
	logic signed [2*DW-1:0]  sqy_s2 [3];
	logic signed [DTW-1:0]   dot_s2 [3], dot_s3 [3], dot_s4 [3], dot_s5 [3];
	logic                    al_s2 [3], al_s3 [3], al_s4 [3], al_s5 [3], al_s6 [3];
	logic [C-1:0]            f_s3 [3];
	logic [2*C-1:0]          ff_s4 [3];
	logic [2*C-1:0]          ff2_s5 [3];
	logic signed [PW-1:0]    prod_s6 [3];
	logic signed [SW-1:0]    sum_s7;

	logic signed [DTW-1:0]   dot_c [3];
	logic signed [FW-1:0]    f_c [3];
	logic signed [SW-1:0]    ctb_c [3];
	logic signed [VW-1:0]    scaled, vsh;
	logic signed [15:0]      sat;

	logic [OCW-1:0]          o_count;
	logic                    o_empty, o_full;

	always_comb begin
		infl  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5) + 3'(v_s6)
			+ 3'(v_s7);
		q_pop = q_valid &&
			((5'(o_count) + 5'(infl)) < 5'(snd_pkg::OUT_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dot_c[k] = DTW'(dx_s1[k]) * DTW'(snd_pkg::grad_x(g_s1[k]))
				+ DTW'(dy_s1[k]) * DTW'(snd_pkg::grad_y(g_s1[k]));
			f_c[k]   = HALF - FW'(sqx_s2[k] >>> C) - FW'(sqy_s2[k] >>> C);
			ctb_c[k] = al_s6[k] ? SW'(prod_s6[k] >>> C) : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dx_s1[k]   <= q_data[k*CW +: DW];
			dy_s1[k]   <= q_data[k*CW + DW +: DW];
			g_s1[k]    <= q_data[k*CW + 2*DW +: 3];
			al_s1[k]   <= q_data[k*CW + 2*DW + 3];
			sqx_s2[k]  <= SQW'(dx_s1[k]) * SQW'(dx_s1[k]);
			sqy_s2[k]  <= SQW'(dy_s1[k]) * SQW'(dy_s1[k]);
			dot_s2[k]  <= dot_c[k];
			al_s2[k]   <= al_s1[k];
			f_s3[k]    <= f_c[k][C-1:0];
			al_s3[k]   <= al_s2[k] && !f_c[k][FW-1];
			dot_s3[k]  <= dot_s2[k];
			ff_s4[k]   <= MW'(f_s3[k]) * MW'(f_s3[k]);
			al_s4[k]   <= al_s3[k];
			dot_s4[k]  <= dot_s3[k];
			ff2_s5[k]  <= MW'(ff_s4[k][2*C-1:C]) * MW'(ff_s4[k][2*C-1:C]);
			al_s5[k]   <= al_s4[k];
			dot_s5[k]  <= dot_s4[k];
			prod_s6[k] <= PW'($signed({1'b0, ff2_s5[k][2*C-1:C]})) * PW'(dot_s5[k]);
			al_s6[k]   <= al_s5[k];
		end
		sum_s7 <= ctb_c[0] + ctb_c[1] + ctb_c[2];
	end

	always_comb begin
		scaled = VW'(sum_s7) * VW'(snd_pkg::NOISE_SCALE);
		vsh    = (scaled >>> SR) <<< SL;
		if (vsh > VW'(32767)) begin
			sat = 16'sd32767;
		end else if (vsh < VW'(-32768)) begin
			sat = -16'sd32768;
		end else begin
			sat = 16'(vsh);
		end
	end

	snd_fifo #(
		.W     (16),
		.DEPTH (snd_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s7),
		.push_data (sat),
		.pop       (out_valid && out_ready),
		.head      (noise_value),
		.empty     (o_empty),
		.full      (o_full),
		.count     (o_count)
	);

	assign out_valid = !o_empty && !(o_full && 1'b0);

endmodule

@@ rtl/simplex_noise_2d.sv @@
// ----------------------------------------------------------------------------
// simplex_noise_2d
// 2D simplex noise on signed fixed-point points, seeded permutation table.
// ----------------------------------------------------------------------------
//
//   channel   signals                                 dir
//   config    psel penable pwrite paddr pwdata        in   (prdata, pready out)
//   point     in_valid in_ready x_coord y_coord       in
//   noise     out_valid out_ready noise_value         out
//
// One point per cycle sustained while no table rebuild runs and the output is
// not stalled; path: 6 front stages, queue, 7 back stages, output FIFO.
// After reset and after every seed write the table is rebuilt: an identity
// fill of 256 entries, then 255 swaps (LCG step, bit-serial remainder, read,
// capture, two writes), all with in_ready low.
// Output stalls fill the output FIFO, then the queue, then drop in_ready.
//
module simplex_noise_2d #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS   = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);

`include "simplex_noise_2d_defines.svh"

	localparam int CW = 2 * (COORD_FRAC_BITS + 2) + 4;
	localparam int QW = 3 * CW;

	logic [31:0]               seed_q;
	logic                      seed_wr;
	snd_pkg::shf_ctrl_t        ctrl;
	logic [7:0]                rd_data0, rd_data1;
	logic                      q_push, q_pop, q_empty, q_full;
	logic [QW-1:0]             q_in, q_head;
	logic [snd_pkg::QCNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && pready
		&& (paddr[2] == snd_pkg::REG_SEED);
	assign prdata  = (paddr[2] == snd_pkg::REG_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (seed_wr) begin
			seed_q <= pwdata;
		end
	end

	snd_shuffle u_shuffle (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed_wr  (seed_wr),
		.seed_val (pwdata),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1),
		.ctrl     (ctrl)
	);

	snd_front #(
		.C (COORD_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.q_count   (q_count),
		.ctrl      (ctrl),
		.rd_data0  (rd_data0),
		.rd_data1  (rd_data1),
		.push      (q_push),
		.push_data (q_in)
	);

	snd_fifo #(
		.W     (QW),
		.DEPTH (snd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full),
		.count     (q_count)
	);

	snd_back #(
		.C (COORD_FRAC_BITS),
		.O (OUT_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (!q_empty),
		.q_data      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.noise_value (noise_value)
	);

	// front credit must keep the queue from overflowing
	`SND_ASSERT_IMP(a_queue_no_overflow, clk, arst_n, q_push, !q_full)
	// a seed write always starts a table rebuild
	`SND_ASSERT_NXT(a_seed_rebuild, clk, arst_n, seed_wr, ctrl.busy)
	// occupancy tracks a lone push
	`SND_ASSERT_NXT(a_queue_count, clk, arst_n, q_push && !q_pop, q_count == $past(q_count) + 4'd1)

endmodule
